FILE: src/range_min_segment_tree_unit_macros.svh
// Assertion macros shared by the checkers of the range minimum tree unit.
// No dependencies; include with the bare file name.
`ifndef RANGE_MIN_SEGMENT_TREE_UNIT_MACROS_SVH
`define RANGE_MIN_SEGMENT_TREE_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RMST_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");

// Next-cycle implication, disabled while reset is asserted.
`define RMST_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`endif

FILE: src/rmst_pkg.sv
// Shared types and constants of the range minimum tree unit.
// No dependencies.
package rmst_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned IDX_W  = 11;

  // Identity for min: the largest positive 32-bit value.
  localparam logic signed [DATA_W-1:0] IDENTITY_MIN = 32'sh7FFF_FFFF;

  // Element count after reset.
  localparam logic [IDX_W-1:0] COUNT_RESET = 11'd1024;

  // Command codes, as carried on the cmd field.
  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } op_e;

  // Command from the front end to the sequencer.
  typedef struct packed {
    logic go;
    op_e  op;
  } seq_ctrl_t;

  // Sequencer status back to the front end.
  typedef struct packed {
    logic busy;
    logic done;
  } seq_stat_t;

endpackage

FILE: src/range_min_segment_tree_unit.sv
// Range minimum segment tree: front end, element count register, results.
// Depends on rmst_pkg and rmst_sequencer.
//
// Usage. Commands enter on start/busy: a command beat is taken at a clock
// edge where start is high and busy is low. cmd selects a write of one
// element (left_index, new_value) or a query of the minimum over
// left_index..right_index. A write that lands in range gives no result; a
// query, or a write with a bad index, gives one result beat, marked by
// result_valid_o for one cycle. The receiver cannot stall: it must take
// each result in the cycle shown.
// Bad indices are caught up front and answer in the cycle after the beat.
// A good write stores the leaf and then rewrites one ancestor a cycle up to
// the root, holding busy until the root has been written.
// A good query walks both interval edges, one level at a time in S_Q_A and
// then S_Q_B over the one memory read port, until the edges meet
// (sooner for narrow ranges), and then answers.
// The element count is written on the cfg channel; the user must do so only while idle; the block does not enforce it.
// After reset a clearing pass sets all 2*MAX_ELEMENTS nodes to the largest
// positive value, one node a cycle; busy is high during those cycles.
module range_min_segment_tree_unit #(
  parameter int MAX_ELEMENTS = 1024
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic                                cmd_i,
  input  logic [rmst_pkg::IDX_W-1:0]          left_index_i,
  input  logic [rmst_pkg::IDX_W-1:0]          right_index_i,
  input  logic signed [rmst_pkg::DATA_W-1:0]  new_value_i,
  output logic                                result_valid_o,
  output logic signed [rmst_pkg::DATA_W-1:0]  range_minimum_o,
  output logic                                range_error_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [rmst_pkg::IDX_W-1:0]          cfg_data_i
);

  localparam int NW = $clog2(2 * MAX_ELEMENTS);
  localparam int NB = NW + 1;
  localparam int MW = $clog2(MAX_ELEMENTS + 1);
  localparam int CW = (rmst_pkg::IDX_W > MW) ? rmst_pkg::IDX_W : MW;

  logic [rmst_pkg::IDX_W-1:0]          count_q;
  logic [CW-1:0]                       active_n;
  logic [CW-1:0]                       lo_w;
  logic [CW-1:0]                       hi_w;
  logic                                lo_ok;
  logic                                hi_ok;
  logic                                accept;
  logic                                is_query;
  logic                                bad;
  rmst_pkg::seq_ctrl_t                 ctrl;
  rmst_pkg::seq_stat_t                 stat;
  logic [NB-1:0]                       lo_node;
  logic [NB-1:0]                       hi_node;
  logic signed [rmst_pkg::DATA_W-1:0]  seq_result;
  logic                                out_valid_q;
  logic signed [rmst_pkg::DATA_W-1:0]  out_min_q;
  logic                                out_err_q;

  // Element count register; the user must write it only while idle; the block does not enforce it.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= rmst_pkg::COUNT_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      count_q <= cfg_data_i;
    end
  end

  // Effective count saturates at the tree size.
  assign active_n = (CW'(count_q) > CW'(MAX_ELEMENTS)) ? CW'(MAX_ELEMENTS) : CW'(count_q);

  // Bound checks.
  assign lo_w  = CW'(left_index_i);
  assign hi_w  = CW'(right_index_i);
  assign lo_ok = (left_index_i != '0) && (lo_w <= active_n);
  assign hi_ok = (right_index_i != '0) && (hi_w <= active_n);

  assign accept   = start && !busy;
  assign is_query = (rmst_pkg::op_e'(cmd_i) == rmst_pkg::OP_QUERY);
  assign bad      = is_query ? !(lo_ok && hi_ok && (left_index_i <= right_index_i)) : !lo_ok;

  // Leaf positions of the half-open interval [lo, hi + 1).
  assign lo_node = NB'(MAX_ELEMENTS) + NB'(left_index_i) - NB'(1);
  assign hi_node = NB'(MAX_ELEMENTS) + NB'(right_index_i);

  assign ctrl.go = accept && !bad;
  assign ctrl.op = rmst_pkg::op_e'(cmd_i);

  rmst_sequencer #(
    .MAX_ELEMENTS (MAX_ELEMENTS)
  ) u_seq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (ctrl),
    .lo_node_i (lo_node),
    .hi_node_i (hi_node),
    .value_i   (new_value_i),
    .stat_o    (stat),
    .result_o  (seq_result)
  );

  assign busy = stat.busy;

  // Result register: either an error answer or a finished query.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_err_q   <= 1'b0;
    end else begin
      out_valid_q <= (accept && bad) || stat.done;
      out_err_q   <= accept && bad;
    end
  end

  always_ff @(posedge clk_i) begin
    out_min_q <= stat.done ? seq_result : '0;
  end

  assign result_valid_o  = out_valid_q;
  assign range_minimum_o = out_min_q;
  assign range_error_o   = out_err_q;

endmodule

FILE: src/rmst_min_unit.sv
// Shared signed minimum unit used by both the update and the query walk.
// Depends on rmst_pkg.
module rmst_min_unit (
  input  logic signed [rmst_pkg::DATA_W-1:0] a_i,
  input  logic signed [rmst_pkg::DATA_W-1:0] b_i,
  output logic signed [rmst_pkg::DATA_W-1:0] min_o
);

  // One signed compare and a select.
  assign min_o = (b_i < a_i) ? b_i : a_i;

endmodule

FILE: src/rmst_sequencer.sv
// Node memory and the sequencer that walks the tree for updates and queries.
// Depends on rmst_pkg and rmst_min_unit.
module rmst_sequencer #(
  parameter int MAX_ELEMENTS = 1024
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  rmst_pkg::seq_ctrl_t                  ctrl_i,
  input  logic [$clog2(2*MAX_ELEMENTS):0]      lo_node_i,
  input  logic [$clog2(2*MAX_ELEMENTS):0]      hi_node_i,
  input  logic signed [rmst_pkg::DATA_W-1:0]   value_i,
  output rmst_pkg::seq_stat_t                  stat_o,
  output logic signed [rmst_pkg::DATA_W-1:0]   result_o
);

  localparam int NODES = 2 * MAX_ELEMENTS;
  localparam int NW    = $clog2(NODES);
  localparam int NB    = NW + 1;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_W_LEAF,
    S_W_UP,
    S_Q_A,
    S_Q_B,
    S_Q_DONE
  } state_e;

  state_e                              state_q, state_d;
  logic [NB-1:0]                       node_q, node_d;
  logic [NB-1:0]                       b_q, b_d;
  logic signed [rmst_pkg::DATA_W-1:0]  acc_q, acc_d;
  logic                                pend_q, pend_d;
  logic [NW-1:0]                       clr_q, clr_d;

  logic                                mem_we;
  logic [NW-1:0]                       mem_waddr;
  logic signed [rmst_pkg::DATA_W-1:0]  mem_wdata;
  logic [NW-1:0]                       mem_raddr;
  logic signed [rmst_pkg::DATA_W-1:0]  rdata_q;
  logic signed [rmst_pkg::DATA_W-1:0]  min_val;

  logic signed [rmst_pkg::DATA_W-1:0]  mem [NODES];

  // Node memory: one write port, one read port with registered data.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem[mem_raddr];
  end

  // The one comparator folds each fetched node into the running minimum.
  rmst_min_unit u_min (
    .a_i   (acc_q),
    .b_i   (rdata_q),
    .min_o (min_val)
  );

  // Next-state and memory control.
  always_comb begin
    logic [NB-1:0] parent;
    logic [NB-1:0] sib;
    logic [NB-1:0] bb;
    parent    = node_q >> 1;
    sib       = parent ^ NB'(1);
    bb        = b_q;
    state_d   = state_q;
    node_d    = node_q;
    b_d       = b_q;
    acc_d     = acc_q;
    pend_d    = 1'b0;
    clr_d     = clr_q;
    mem_we    = 1'b0;
    mem_waddr = node_q[NW-1:0];
    mem_wdata = acc_q;
    mem_raddr = node_q[NW-1:0];

    case (state_q)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = rmst_pkg::IDENTITY_MIN;
        clr_d     = clr_q + NW'(1);
        if (clr_q == NW'(NODES - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (ctrl_i.go) begin
          node_d = lo_node_i;
          b_d    = hi_node_i;
          if (ctrl_i.op == rmst_pkg::OP_WRITE) begin
            acc_d   = value_i;
            state_d = S_W_LEAF;
          end else begin
            acc_d   = rmst_pkg::IDENTITY_MIN;
            state_d = S_Q_A;
          end
        end
      end
      // Store the leaf and fetch its sibling.
      S_W_LEAF: begin
        mem_we    = 1'b1;
        mem_waddr = node_q[NW-1:0];
        mem_wdata = acc_q;
        bb        = node_q ^ NB'(1);
        mem_raddr = bb[NW-1:0];
        state_d   = S_W_UP;
      end
      // One level a cycle: parent = min(path value, sibling).
      S_W_UP: begin
        mem_we    = 1'b1;
        mem_waddr = parent[NW-1:0];
        mem_wdata = min_val;
        acc_d     = min_val;
        node_d    = parent;
        mem_raddr = sib[NW-1:0];
        if (parent == NB'(1)) begin
          state_d = S_IDLE;
        end
      end
      // Left edge of the half-open interval.
      S_Q_A: begin
        if (pend_q) begin
          acc_d = min_val;
        end
        if (node_q < b_q) begin
          if (node_q[0]) begin
            mem_raddr = node_q[NW-1:0];
            pend_d    = 1'b1;
            node_d    = node_q + NB'(1);
          end
          state_d = S_Q_B;
        end else begin
          state_d = S_Q_DONE;
        end
      end
      // Right edge, then both bounds climb one level.
      S_Q_B: begin
        if (pend_q) begin
          acc_d = min_val;
        end
        if (b_q[0]) begin
          bb        = b_q - NB'(1);
          mem_raddr = bb[NW-1:0];
          pend_d    = 1'b1;
        end
        b_d     = bb >> 1;
        node_d  = node_q >> 1;
        state_d = S_Q_A;
      end
      S_Q_DONE: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State and working registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      pend_q  <= 1'b0;
      node_q  <= '0;
      b_q     <= '0;
      acc_q   <= rmst_pkg::IDENTITY_MIN;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      pend_q  <= pend_d;
      node_q  <= node_d;
      b_q     <= b_d;
      acc_q   <= acc_d;
    end
  end

  assign stat_o.busy = (state_q != S_IDLE);
  assign stat_o.done = (state_q == S_Q_DONE);
  assign result_o    = acc_q;

endmodule

FILE: src/rmst_checker.sv
// Port-level checks of the range minimum tree unit, bound to the top level.
// Depends on rmst_pkg and range_min_segment_tree_unit_macros.svh.
`include "range_min_segment_tree_unit_macros.svh"

module rmst_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                start,
  input logic                                busy,
  input logic                                cmd_i,
  input logic [rmst_pkg::IDX_W-1:0]          left_index_i,
  input logic [rmst_pkg::IDX_W-1:0]          right_index_i,
  input logic                                result_valid_o,
  input logic signed [rmst_pkg::DATA_W-1:0]  range_minimum_o,
  input logic                                range_error_o
);

  // An error answer always carries a zero minimum.
  `RMST_ASSERT_IMP(a_err_zero, clk_i, rst_ni, result_valid_o && range_error_o, range_minimum_o == '0)

  // A reversed query range is answered with an error in the next cycle.
  `RMST_ASSERT_NXT(a_rev_err, clk_i, rst_ni, start && !busy && (cmd_i == rmst_pkg::OP_QUERY) && (left_index_i > right_index_i), result_valid_o && range_error_o)

  // A taken query either answers at once or keeps the unit busy.
  `RMST_ASSERT_NXT(a_query_prog, clk_i, rst_ni, start && !busy && (cmd_i == rmst_pkg::OP_QUERY), busy || result_valid_o)

  // Results are shown only once the tree walk has finished.
  `RMST_ASSERT_IMP(a_res_idle, clk_i, rst_ni, result_valid_o, !busy)

endmodule

bind range_min_segment_tree_unit rmst_checker u_rmst_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .start           (start),
  .busy            (busy),
  .cmd_i           (cmd_i),
  .left_index_i    (left_index_i),
  .right_index_i   (right_index_i),
  .result_valid_o  (result_valid_o),
  .range_minimum_o (range_minimum_o),
  .range_error_o   (range_error_o)
);

FILE: dv/range_min_segment_tree_unit_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for the range minimum segment tree unit.
// Depends on rmst_pkg and the range_min_segment_tree_unit RTL; no files are read.
module range_min_segment_tree_unit_test;
  import rmst_pkg::*;

  localparam int TREE_ELEMENTS = 1024;
  localparam int INDEX_SPAN = 1 << IDX_W;
  // Longest command is a wide query.
  localparam int SETTLE_CYCLES = 32;
  localparam int PHASE_COUNT = 7;

  // Phases of element count, sender idling and random command total.
  localparam int unsigned PHASE_COUNTS [PHASE_COUNT] = '{1024, 1, 2047, 0, 37, 1024, 300};
  localparam int unsigned PHASE_IDLE [PHASE_COUNT] = '{0, 45, 6, 45, 0, 45, 6};
  localparam int unsigned PHASE_ITEMS [PHASE_COUNT] = '{90, 40, 100, 20, 100, 100, 100};

  typedef struct {
    op_e                      op;
    logic [IDX_W-1:0]         left;
    logic [IDX_W-1:0]         right;
    logic signed [DATA_W-1:0] value;
  } tree_cmd_t;

  typedef struct {
    logic signed [DATA_W-1:0] minimum;
    logic                     error;
  } range_answer_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     start = 1'b0;
  logic                     busy;
  logic                     cmd_i = 1'b0;
  logic [IDX_W-1:0]         left_index_i = '0;
  logic [IDX_W-1:0]         right_index_i = '0;
  logic signed [DATA_W-1:0] new_value_i = '0;
  logic                     result_valid_o;
  logic signed [DATA_W-1:0] range_minimum_o;
  logic                     range_error_o;
  logic                     cfg_valid_i = 1'b0;
  logic                     cfg_ready_o;
  logic [IDX_W-1:0]         cfg_data_i = '0;

  // Shadow of the array contents and of the element count register.
  logic signed [DATA_W-1:0] element_values [1:TREE_ELEMENTS];
  int unsigned              element_count_q = TREE_ELEMENTS;

  tree_cmd_t     cmd_queue[$];
  range_answer_t pending_answers[$];
  tree_cmd_t     driven_cmd;
  int unsigned   sender_idle_pct = 0;
  int unsigned   fail_count = 0;

  range_min_segment_tree_unit #(
    .MAX_ELEMENTS(TREE_ELEMENTS)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .cmd_i          (cmd_i),
    .left_index_i   (left_index_i),
    .right_index_i  (right_index_i),
    .new_value_i    (new_value_i),
    .result_valid_o (result_valid_o),
    .range_minimum_o(range_minimum_o),
    .range_error_o  (range_error_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  initial begin
    #5ms;
    $display("status: fail");
    $finish;
  end

  // Counts above the tree size act as the full tree.
  function automatic int unsigned usable_count(input int unsigned count);
    return (count > TREE_ELEMENTS) ? TREE_ELEMENTS : count;
  endfunction

  // Updates the shadow array for one accepted command and records its answer, if any.
  task automatic apply_command(input tree_cmd_t c);
    int unsigned              n;
    logic signed [DATA_W-1:0] lowest;
    range_answer_t            answer;
    n = usable_count(element_count_q);
    answer.minimum = '0;
    answer.error = 1'b1;
    if (c.op == OP_WRITE) begin
      if (c.left >= 1 && c.left <= n) begin
        element_values[c.left] = c.value;
        return;
      end
    end else if (c.left >= 1 && c.right <= n && c.left <= c.right) begin
      lowest = IDENTITY_MIN;
      for (int i = c.left; i <= c.right; i++) begin
        if (element_values[i] < lowest) lowest = element_values[i];
      end
      answer.minimum = lowest;
      answer.error = 1'b0;
    end
    pending_answers.push_back(answer);
  endtask

  task automatic queue_command(input op_e op, input int unsigned left,
                               input int unsigned right, input logic signed [DATA_W-1:0] value);
    tree_cmd_t c;
    c.op = op;
    c.left = left[IDX_W-1:0];
    c.right = right[IDX_W-1:0];
    c.value = value;
    cmd_queue.push_back(c);
  endtask

  function automatic logic signed [DATA_W-1:0] random_value();
    case ($urandom_range(7))
      0: return 32'sh8000_0000;
      1: return 32'sh7FFF_FFFF;
      2: return $signed(32'($urandom_range(2) - 1));
      default: return $signed($urandom);
    endcase
  endfunction

  // Mostly well-formed writes and queries inside the active range, the rest noise.
  task automatic queue_random_command(input int unsigned count);
    int unsigned n;
    int unsigned roll;
    int unsigned left;
    n = usable_count(count);
    roll = $urandom_range(99);
    if (n > 0 && roll < 45) begin
      queue_command(OP_WRITE, $urandom_range(n, 1), $urandom_range(INDEX_SPAN - 1),
                    random_value());
    end else if (n > 0 && roll < 85) begin
      left = $urandom_range(n, 1);
      if ($urandom_range(3) == 0)
        queue_command(OP_QUERY, left, $urandom_range(n < left + 8 ? n : left + 8, left),
                      random_value());
      else
        queue_command(OP_QUERY, left, $urandom_range(n, left), random_value());
    end else begin
      queue_command($urandom_range(1) ? OP_QUERY : OP_WRITE, $urandom_range(INDEX_SPAN - 1),
                    $urandom_range(INDEX_SPAN - 1), random_value());
    end
  endtask

  // Blocks until every command is taken and every answer has come back.
  task automatic wait_idle();
    while (cmd_queue.size() != 0 || start || pending_answers.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_element_count(input int unsigned count);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= count[IDX_W-1:0];
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    element_count_q = count;
  endtask

  // Command driver: presents the next beat once the current one is taken.
  always @(posedge clk_i or negedge rst_ni) begin
    logic next_start;
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      next_start = start;
      if (start && !busy) begin
        apply_command(driven_cmd);
        next_start = 1'b0;
      end
      if (!next_start && cmd_queue.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
        driven_cmd = cmd_queue.pop_front();
        cmd_i <= driven_cmd.op;
        left_index_i <= driven_cmd.left;
        right_index_i <= driven_cmd.right;
        new_value_i <= driven_cmd.value;
        next_start = 1'b1;
      end
      start <= next_start;
    end
  end

  // Result monitor: each strobed beat is checked against the oldest answer.
  always @(posedge clk_i) begin
    range_answer_t want;
    if (rst_ni && result_valid_o) begin
      if (pending_answers.size() == 0) begin
        $error("result beat with no answer pending");
        fail_count++;
      end else begin
        want = pending_answers.pop_front();
        if (range_minimum_o !== want.minimum) begin
          $error("range_minimum: expected %0d, got %0d", want.minimum, range_minimum_o);
          fail_count++;
        end
        if (range_error_o !== want.error) begin
          $error("range_error: expected %0d, got %0d", want.error, range_error_o);
          fail_count++;
        end
      end
    end
  end

  // Stimulus: directed commands, then the random phases.
  initial begin
    for (int i = 1; i <= TREE_ELEMENTS; i++) element_values[i] = IDENTITY_MIN;

    // Directed commands at the reset count: unwritten leaves, edges and bad ranges.
    queue_command(OP_QUERY, 1, 1024, 0);
    queue_command(OP_WRITE, 1, 0, 32'sh8000_0000);
    queue_command(OP_WRITE, 1024, 2047, 32'sh7FFF_FFFF);
    queue_command(OP_WRITE, 512, 1024, 0);
    queue_command(OP_WRITE, 0, 5, 7);
    queue_command(OP_WRITE, 1025, 0, -7);
    queue_command(OP_WRITE, 2047, 2047, -1);
    queue_command(OP_QUERY, 1, 1024, -1);
    queue_command(OP_QUERY, 1, 1, 32'sh7FFF_FFFF);
    queue_command(OP_QUERY, 1024, 1024, 0);
    queue_command(OP_QUERY, 2, 1023, 32'sh8000_0000);
    queue_command(OP_QUERY, 5, 4, 0);
    queue_command(OP_QUERY, 0, 5, 0);
    queue_command(OP_QUERY, 3, 0, 0);
    queue_command(OP_QUERY, 1, 1025, 0);
    queue_command(OP_QUERY, 2047, 2047, 0);
    queue_command(OP_WRITE, 700, 1, -1);
    queue_command(OP_QUERY, 600, 800, 0);
    queue_command(OP_WRITE, 1, 3, 5);
    queue_command(OP_QUERY, 1, 2, 0);
    queue_command(OP_QUERY, 1, 1024, 0);

    for (int p = 0; p < PHASE_COUNT; p++) begin
      // The sender holds off here until every answer is back.
      if (p != 0) begin
        wait_idle();
        write_element_count(PHASE_COUNTS[p]);
        // Shrunk ranges keep old leaves; probe both sides of the new bound.
        queue_command(OP_QUERY, 1, usable_count(PHASE_COUNTS[p]), 0);
        queue_command(OP_WRITE, usable_count(PHASE_COUNTS[p]) + 1, 1, 9);
        queue_command(OP_QUERY, 1, usable_count(PHASE_COUNTS[p]) + 1, 0);
      end
      sender_idle_pct = PHASE_IDLE[p];
      for (int k = 0; k < PHASE_ITEMS[p]; k++) queue_random_command(PHASE_COUNTS[p]);
    end

    wait_idle();
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
